FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file of the im2col block.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/im2col_pkg.sv
// Shared types, widths and constant tables for the im2col address generator.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package im2col_pkg;

  localparam int CfgIdxW    = 4;
  localparam int CfgDataW   = 13;
  localparam int SideW      = 13;
  localparam int KernW      = 5;
  localparam int StrideW    = 4;
  localparam int PadW       = 4;
  localparam int ColRowW    = 18;
  localparam int PixW       = 12;
  localparam int OffsetW    = 34;
  localparam int RecipShift = 24;
  localparam int RecipW     = RecipShift + 1;

  typedef enum logic [CfgIdxW-1:0] {
    RegInHeight     = 4'd0,
    RegInWidth      = 4'd1,
    RegKernelHeight = 4'd2,
    RegKernelWidth  = 4'd3,
    RegStrideRows   = 4'd4,
    RegStrideCols   = 4'd5,
    RegPadAbove     = 4'd6,
    RegPadBefore    = 4'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [SideW-1:0]   img_height;
    logic [SideW-1:0]   img_width;
    logic [KernW-1:0]   kernel_height;
    logic [KernW-1:0]   kernel_width;
    logic [StrideW-1:0] stride_rows;
    logic [StrideW-1:0] stride_cols;
    logic [PadW-1:0]    pad_above;
    logic [PadW-1:0]    pad_before;
  } cfg_t;

  typedef struct packed {
    logic [PixW-1:0] out_row;
    logic [PixW-1:0] out_col;
  } pix_sb_t;

  typedef struct packed {
    logic [KernW-1:0] kcol;
    logic [PixW-1:0]  out_row;
    logic [PixW-1:0]  out_col;
  } kpix_sb_t;

  // floor(2^24 / k); a kernel size of zero counts as one
  localparam logic [RecipW-1:0] RECIP [32] = '{
    25'd16777216, 25'd16777216, 25'd8388608,  25'd5592405,
    25'd4194304,  25'd3355443,  25'd2796202,  25'd2396745,
    25'd2097152,  25'd1864135,  25'd1677721,  25'd1525201,
    25'd1398101,  25'd1290555,  25'd1198372,  25'd1118481,
    25'd1048576,  25'd986895,   25'd932067,   25'd883011,
    25'd838860,   25'd798915,   25'd762600,   25'd729444,
    25'd699050,   25'd671088,   25'd645277,   25'd621378,
    25'd599186,   25'd578524,   25'd559240,   25'd541200
  };

endpackage

FILE: rtl/im2col_div.sv
// Two-stage divider by a small run-time constant: reciprocal multiply, then
// one remainder correction. Depends on im2col_pkg.
`timescale 1ns / 1ps

module im2col_div #(
  parameter int SbW = 1
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [im2col_pkg::ColRowW-1:0]       dividend_i,
  input  logic [im2col_pkg::KernW-1:0]         divisor_i,
  input  logic [im2col_pkg::RecipW-1:0]        recip_i,
  input  logic [SbW-1:0]                       sb_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [im2col_pkg::ColRowW-1:0]       quot_o,
  output logic [im2col_pkg::KernW-1:0]         rem_o,
  output logic [SbW-1:0]                       sb_o
);
  import im2col_pkg::*;

  localparam int ProdW = ColRowW + RecipW;
  localparam int QdW   = ColRowW + KernW;

  logic                 v1_q, v2_q, en1, en2;
  logic [ProdW-1:0]     prod;
  logic [ColRowW-1:0]   q0_d, q0_q, num_q;
  logic [SbW-1:0]       sb1_q, sb2_q;
  logic [QdW-1:0]       qd;
  logic [ColRowW-1:0]   r0;
  logic [ColRowW-1:0]   quot_d, quot_q;
  logic [KernW-1:0]     rem_d, rem_q;

  always_comb begin
    en2        = !v2_q || !out_stall_i;
    en1        = !v1_q || en2;
    in_stall_o = !en1;
  end

  always_comb begin
    prod = ProdW'(dividend_i) * ProdW'(recip_i);
    q0_d = prod[RecipShift +: ColRowW];
  end

  always_comb begin
    qd = QdW'(q0_q) * QdW'(divisor_i);
    r0 = num_q - qd[ColRowW-1:0];
    if (r0 >= ColRowW'(divisor_i)) begin
      quot_d = q0_q + ColRowW'(1);
      rem_d  = KernW'(r0 - ColRowW'(divisor_i));
    end else begin
      quot_d = q0_q;
      rem_d  = r0[KernW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      q0_q  <= q0_d;
      num_q <= dividend_i;
      sb1_q <= sb_i;
    end
    if (en2 && v1_q) begin
      quot_q <= quot_d;
      rem_q  <= rem_d;
      sb2_q  <= sb1_q;
    end
  end

  assign out_valid_o = v2_q;
  assign quot_o      = quot_q;
  assign rem_o       = rem_q;
  assign sb_o        = sb2_q;

endmodule

FILE: rtl/im2col_addr.sv
// Three-stage address unit: stride, padding and bounds check, then the
// plane offset in two multiply stages. Depends on im2col_pkg.
`timescale 1ns / 1ps

module im2col_addr (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  im2col_pkg::cfg_t                  cfg_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [im2col_pkg::ColRowW-1:0]    chan_i,
  input  logic [im2col_pkg::KernW-1:0]      krow_i,
  input  logic [im2col_pkg::KernW-1:0]      kcol_i,
  input  logic [im2col_pkg::PixW-1:0]       out_row_i,
  input  logic [im2col_pkg::PixW-1:0]       out_col_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [im2col_pkg::OffsetW-1:0]    source_offset_o,
  output logic                              is_padding_o
);
  import im2col_pkg::*;

  localparam int ScW   = PixW + StrideW;
  localparam int PosW  = ScW + 1;
  localparam int BaseW = ColRowW + SideW + 1;
  localparam int MulW  = BaseW + SideW;

  logic               v1_q, v2_q, v3_q, en1, en2, en3;
  logic [ScW-1:0]     ors, ocs;
  logic [PosW-1:0]    rowv, colv, row_lo, col_lo;
  logic               pad_d;
  logic [ColRowW-1:0] chan_q;
  logic [SideW-1:0]   row_q, col_q, col2_q;
  logic               pad_q, pad2_q, pad3_q;
  logic [BaseW-1:0]   base_d, base_q;
  logic [MulW-1:0]    mul;
  logic [OffsetW-1:0] off_d, off_q;

  always_comb begin
    en3        = !v3_q || !out_stall_i;
    en2        = !v2_q || en3;
    en1        = !v1_q || en2;
    in_stall_o = !en1;
  end

  always_comb begin
    ors    = ScW'(out_row_i) * ScW'(cfg_i.stride_rows);
    ocs    = ScW'(out_col_i) * ScW'(cfg_i.stride_cols);
    rowv   = PosW'(krow_i) + PosW'(ors);
    colv   = PosW'(kcol_i) + PosW'(ocs);
    row_lo = rowv - PosW'(cfg_i.pad_above);
    col_lo = colv - PosW'(cfg_i.pad_before);
    pad_d  = (rowv < PosW'(cfg_i.pad_above)) || (row_lo >= PosW'(cfg_i.img_height)) ||
             (colv < PosW'(cfg_i.pad_before)) || (col_lo >= PosW'(cfg_i.img_width));
  end

  always_comb begin
    base_d = BaseW'(chan_q) * BaseW'(cfg_i.img_height) + BaseW'(row_q);
    mul    = MulW'(base_q) * MulW'(cfg_i.img_width);
    off_d  = pad2_q ? '0 : mul[OffsetW-1:0] + OffsetW'(col2_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      chan_q <= chan_i;
      row_q  <= row_lo[SideW-1:0];
      col_q  <= col_lo[SideW-1:0];
      pad_q  <= pad_d;
    end
    if (en2 && v1_q) begin
      base_q <= base_d;
      col2_q <= col_q;
      pad2_q <= pad_q;
    end
    if (en3 && v2_q) begin
      off_q  <= off_d;
      pad3_q <= pad2_q;
    end
  end

  assign out_valid_o     = v3_q;
  assign source_offset_o = off_q;
  assign is_padding_o    = pad3_q;

endmodule

FILE: rtl/im2col_source_index.sv
// im2col source address generator: takes one im2col coordinate per request
// and returns the input-plane element offset or a padding flag. Depends on
// im2col_pkg, im2col_div and im2col_addr.
`timescale 1ns / 1ps

// Accepts one request per clock while in_stall_o is low and returns one
// result per request, in order. The pipeline is two reciprocal-multiply
// dividers (kernel width, then kernel height, two stages each) followed by
// a bounds stage and two offset multiply stages. Stages close up behind a
// stalled output, so up to seven requests can be in flight. Configuration
// writes are always taken (cfg_ready_o is tied high) and must only happen
// while the pipeline is empty; unknown register indexes are ignored.
module im2col_source_index (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [im2col_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [im2col_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [im2col_pkg::ColRowW-1:0]     col_row_i,
  input  logic [im2col_pkg::PixW-1:0]        out_row_i,
  input  logic [im2col_pkg::PixW-1:0]        out_col_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [im2col_pkg::OffsetW-1:0]     source_offset_o,
  output logic                               is_padding_o
);
  import im2col_pkg::*;

  cfg_t               cfg_q, cfg_d;
  logic [KernW-1:0]   kw_eff, kh_eff;
  pix_sb_t            sb_a_in, sb_a_out;
  kpix_sb_t           sb_b_in, sb_b_out;
  logic               va, vb, sta, stb;
  logic [ColRowW-1:0] qa, chan;
  logic [KernW-1:0]   kcol, krow;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegInHeight:     cfg_d.img_height    = cfg_data_i[SideW-1:0];
        RegInWidth:      cfg_d.img_width     = cfg_data_i[SideW-1:0];
        RegKernelHeight: cfg_d.kernel_height = cfg_data_i[KernW-1:0];
        RegKernelWidth:  cfg_d.kernel_width  = cfg_data_i[KernW-1:0];
        RegStrideRows:   cfg_d.stride_rows   = cfg_data_i[StrideW-1:0];
        RegStrideCols:   cfg_d.stride_cols   = cfg_data_i[StrideW-1:0];
        RegPadAbove:     cfg_d.pad_above     = cfg_data_i[PadW-1:0];
        RegPadBefore:    cfg_d.pad_before    = cfg_data_i[PadW-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.img_height    <= SideW'(1);
      cfg_q.img_width     <= SideW'(1);
      cfg_q.kernel_height <= KernW'(1);
      cfg_q.kernel_width  <= KernW'(1);
      cfg_q.stride_rows   <= StrideW'(1);
      cfg_q.stride_cols   <= StrideW'(1);
      cfg_q.pad_above     <= '0;
      cfg_q.pad_before    <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign kw_eff = (cfg_q.kernel_width  == '0) ? KernW'(1) : cfg_q.kernel_width;
  assign kh_eff = (cfg_q.kernel_height == '0) ? KernW'(1) : cfg_q.kernel_height;

  assign sb_a_in.out_row = out_row_i;
  assign sb_a_in.out_col = out_col_i;

  im2col_div #(
    .SbW ($bits(pix_sb_t))
  ) u_div_w (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .dividend_i  (col_row_i),
    .divisor_i   (kw_eff),
    .recip_i     (RECIP[cfg_q.kernel_width]),
    .sb_i        (sb_a_in),
    .out_valid_o (va),
    .out_stall_i (sta),
    .quot_o      (qa),
    .rem_o       (kcol),
    .sb_o        (sb_a_out)
  );

  assign sb_b_in.kcol    = kcol;
  assign sb_b_in.out_row = sb_a_out.out_row;
  assign sb_b_in.out_col = sb_a_out.out_col;

  im2col_div #(
    .SbW ($bits(kpix_sb_t))
  ) u_div_h (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (va),
    .in_stall_o  (sta),
    .dividend_i  (qa),
    .divisor_i   (kh_eff),
    .recip_i     (RECIP[cfg_q.kernel_height]),
    .sb_i        (sb_b_in),
    .out_valid_o (vb),
    .out_stall_i (stb),
    .quot_o      (chan),
    .rem_o       (krow),
    .sb_o        (sb_b_out)
  );

  im2col_addr u_addr (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .in_valid_i      (vb),
    .in_stall_o      (stb),
    .chan_i          (chan),
    .krow_i          (krow),
    .kcol_i          (sb_b_out.kcol),
    .out_row_i       (sb_b_out.out_row),
    .out_col_i       (sb_b_out.out_col),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .source_offset_o (source_offset_o),
    .is_padding_o    (is_padding_o)
  );

endmodule

FILE: rtl/im2col_chk.sv
// Port-level checker for im2col_source_index, attached by bind.
// Depends on im2col_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module im2col_chk (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               cfg_valid_i,
  input logic                               cfg_ready_o,
  input logic [im2col_pkg::CfgIdxW-1:0]     cfg_index_i,
  input logic [im2col_pkg::CfgDataW-1:0]    cfg_data_i,
  input logic                               in_valid_i,
  input logic                               in_stall_o,
  input logic [im2col_pkg::ColRowW-1:0]     col_row_i,
  input logic [im2col_pkg::PixW-1:0]        out_row_i,
  input logic [im2col_pkg::PixW-1:0]        out_col_i,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic [im2col_pkg::OffsetW-1:0]     source_offset_o,
  input logic                               is_padding_o
);
  import im2col_pkg::*;

  // a padding result never carries an offset
  `ASSERT_IMPL(a_pad_zero, clk_i, rst_ni, out_valid_o && is_padding_o, source_offset_o == '0, "padding result with nonzero offset")

  // the input side only stalls once the pipeline is full behind a stalled result
  `ASSERT_IMPL(a_in_stall_full, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i, "input stalled while pipeline has room")

  // hold a stalled result
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(source_offset_o) && $stable(is_padding_o), "stalled result changed or dropped")

endmodule

bind im2col_source_index im2col_chk u_im2col_chk (.*);
